/* src/grid_dda_raycaster_top_defines.svh */
// ----------------------------------------------------------------------------
// Grid DDA raycaster assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef GRID_DDA_RAYCASTER_TOP_DEFINES_SVH
`define GRID_DDA_RAYCASTER_TOP_DEFINES_SVH

// checked only outside reset
`define GDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge
`define GDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/gdr_pkg.sv */
// ----------------------------------------------------------------------------
// Grid DDA raycaster package
// Constants, configuration layout, codes and inter-module structs.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam int MAP_BITS   = 6;
  localparam int MAP_SIDE   = 1 << MAP_BITS;
  localparam int MAP_CELLS  = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W     = 2 * MAP_BITS;
  localparam int CELL_W     = MAP_BITS + 1;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_SCREEN = 1024;
  localparam int SCR_W      = 11;
  localparam int COL_W      = 10;
  localparam int WALK_LIMIT = 4 * MAP_SIDE;
  localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
  localparam int DIST_W     = 31;
  localparam int DIV_N      = 2 * FRAC_BITS + 1;
  localparam int DIV_D      = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_N + 1);
  localparam int POS_W      = 22;
  localparam int VEC_W      = 19;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 80;
  localparam logic [DIST_W-1:0] DSAT = '1;

  typedef enum logic [2:0] {
    CFG_PLAYER_X      = 3'd0,
    CFG_PLAYER_Y      = 3'd1,
    CFG_VIEW_DIR_X    = 3'd2,
    CFG_VIEW_DIR_Y    = 3'd3,
    CFG_CAM_PLANE_X   = 3'd4,
    CFG_CAM_PLANE_Y   = 3'd5,
    CFG_SCREEN_WIDTH  = 3'd6,
    CFG_SCREEN_HEIGHT = 3'd7
  } gdr_cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } gdr_op_e;

  typedef enum logic [1:0] {
    FACE_EAST  = 2'd0,
    FACE_WEST  = 2'd1,
    FACE_SOUTH = 2'd2,
    FACE_NORTH = 2'd3
  } gdr_face_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CAM_GO,
    S_CAM_WAIT,
    S_MULX,
    S_MULY,
    S_RAYY,
    S_INVX_GO,
    S_INVX_WAIT,
    S_INVY_GO,
    S_INVY_WAIT,
    S_INITX,
    S_INITY,
    S_INITZ,
    S_STEP,
    S_CHECK,
    S_DIST,
    S_LINE_GO,
    S_LINE_WAIT,
    S_FIN
  } gdr_state_e;

  typedef struct packed {
    logic [POS_W-1:0]        player_x;
    logic [POS_W-1:0]        player_y;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] plane_x;
    logic signed [VEC_W-1:0] plane_y;
    logic [SCR_W-1:0]        width;
    logic [SCR_W-1:0]        height;
  } gdr_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } gdr_map_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] num;
    logic [DIV_D-1:0] den;
  } gdr_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_N-1:0] quo;
  } gdr_div_rsp_t;

endpackage

/* src/gdr_div.sv */
// ----------------------------------------------------------------------------
// Grid DDA raycaster divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdr_div import gdr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gdr_div_req_t req_i,
  output gdr_div_rsp_t rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_D-1:0]     rem_q, den_q;
  logic [DIV_N-1:0]     quo_q;
  logic [DIV_D:0]       r;
  logic [DIV_D+1:0]     diff;
  logic                 ge;

  assign r    = {rem_q, quo_q[DIV_N-1]};
  assign diff = {1'b0, r} - {2'b00, den_q};
  assign ge   = ~diff[DIV_D+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_D-1:0] : r[DIV_D-1:0];
      quo_q <= {quo_q[DIV_N-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* src/gdr_map.sv */
// ----------------------------------------------------------------------------
// Grid DDA raycaster wall map
// One-bit cell memory, registered read, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module gdr_map import gdr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gdr_map_req_t req_i,
  output logic         rd_data_o,
  output logic         clear_busy_o
);

  logic              mem_q [MAP_CELLS];
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(MAP_CELLS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= 1'b0;
    end else if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o    = rd_q;
  assign clear_busy_o = clr_busy_q;

endmodule

/* src/gdr_core.sv */
// ----------------------------------------------------------------------------
// Grid DDA raycaster core
// Sequencer: camera ray, reciprocal step lengths, DDA walk, strip extent.
// ----------------------------------------------------------------------------
`include "grid_dda_raycaster_top_defines.svh"

module gdr_core import gdr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gdr_cfg_t              cfg_i,
  input  logic                  clear_busy_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output gdr_map_req_t          map_req_o,
  input  logic                  map_rd_data_i,
  output gdr_div_req_t          div_req_o,
  input  gdr_div_rsp_t          div_rsp_i
);

  gdr_state_e state_q, state_d;

  logic [COL_W-1:0]    col_q;
  logic signed [28:0]  cam_q;
  logic signed [51:0]  prod_q;
  logic signed [31:0]  ray_x_q, ray_y_q;
  logic [DIST_W-1:0]   step_x_q, step_y_q, cross_x_q, cross_y_q, dist_q;
  logic [CELL_W-1:0]   cell_x_q, cell_y_q;
  logic                side_q;
  logic [STEP_W-1:0]   steps_q;
  logic [SCR_W-1:0]    line_q;
  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic                accept, load_out, take_x, wall;
  logic [SCR_W-1:0]    w_eff, h_eff, h2, l2, top, bsum, bottom;
  logic signed [19:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [51:0]  prod_tr, prod_sh;
  logic [31:0]         ray_trunc;
  logic [DIST_W-1:0]   prod_sat, quo_sat, nx_cross, ny_cross;
  logic [DIST_W:0]     sum_x, sum_y, dist_diff;
  logic [31:0]         abs_x, abs_y;
  logic [16:0]         frac_x, frac_y;
  logic [CELL_W-1:0]   nx_cell, ny_cell, rd_x, rd_y;
  gdr_face_e           face;

  assign w_eff = (cfg_i.width == '0) ? SCR_W'(1) : cfg_i.width;
  assign h_eff = (cfg_i.height == '0) ? SCR_W'(1) :
                 (cfg_i.height > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN) : cfg_i.height;

  assign s_axis_tready = (state_q == S_IDLE) && !clear_busy_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MULX: begin
        mul_a = 20'(cfg_i.plane_x);
        mul_b = 32'(cam_q);
      end
      S_MULY: begin
        mul_a = 20'(cfg_i.plane_y);
        mul_b = 32'(cam_q);
      end
      S_INITX: begin
        mul_a = signed'({3'b000, frac_x});
        mul_b = signed'({1'b0, step_x_q});
      end
      S_INITY: begin
        mul_a = signed'({3'b000, frac_y});
        mul_b = signed'({1'b0, step_y_q});
      end
      default: ;
    endcase
  end

  assign prod_tr   = prod_q + (prod_q[51] ? 52'sd65535 : 52'sd0);
  assign ray_trunc = 32'(prod_tr >>> FRAC_BITS);
  assign prod_sh   = prod_q >>> FRAC_BITS;
  assign prod_sat  = (|prod_sh[51:DIST_W]) ? DSAT : prod_sh[DIST_W-1:0];
  assign quo_sat   = (|div_rsp_i.quo[DIV_N-1:DIST_W]) ? DSAT : div_rsp_i.quo[DIST_W-1:0];

  assign abs_x  = ray_x_q[31] ? 32'(-ray_x_q) : 32'(ray_x_q);
  assign abs_y  = ray_y_q[31] ? 32'(-ray_y_q) : 32'(ray_y_q);
  assign frac_x = ray_x_q[31] ? {1'b0, cfg_i.player_x[FRAC_BITS-1:0]}
                              : 17'h10000 - {1'b0, cfg_i.player_x[FRAC_BITS-1:0]};
  assign frac_y = ray_y_q[31] ? {1'b0, cfg_i.player_y[FRAC_BITS-1:0]}
                              : 17'h10000 - {1'b0, cfg_i.player_y[FRAC_BITS-1:0]};

  // one DDA step
  assign take_x   = cross_x_q < cross_y_q;
  assign sum_x    = {1'b0, cross_x_q} + {1'b0, step_x_q};
  assign sum_y    = {1'b0, cross_y_q} + {1'b0, step_y_q};
  assign nx_cross = sum_x[DIST_W] ? DSAT : sum_x[DIST_W-1:0];
  assign ny_cross = sum_y[DIST_W] ? DSAT : sum_y[DIST_W-1:0];
  assign nx_cell  = ray_x_q[31] ? ((cell_x_q == '0) ? '0 : cell_x_q - 1'b1) : cell_x_q + 1'b1;
  assign ny_cell  = ray_y_q[31] ? ((cell_y_q == '0) ? '0 : cell_y_q - 1'b1) : cell_y_q + 1'b1;
  assign rd_x     = take_x ? nx_cell : cell_x_q;
  assign rd_y     = take_x ? cell_y_q : ny_cell;
  assign wall     = map_rd_data_i | cell_x_q[MAP_BITS] | cell_y_q[MAP_BITS];

  assign dist_diff = side_q ? {1'b0, cross_y_q} - {1'b0, step_y_q}
                            : {1'b0, cross_x_q} - {1'b0, step_x_q};

  assign map_req_o.we    = accept && (gdr_op_e'(s_axis_tuser) == OP_WRITE);
  assign map_req_o.waddr = {s_axis_tdata[21:16], s_axis_tdata[15:10]};
  assign map_req_o.wdata = s_axis_tdata[22];
  assign map_req_o.re    = (state_q == S_STEP);
  assign map_req_o.raddr = {rd_y[MAP_BITS-1:0], rd_x[MAP_BITS-1:0]};

  always_comb begin
    div_req_o.start = 1'b0;
    div_req_o.num   = '0;
    div_req_o.den   = '0;
    case (state_q)
      S_CAM_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = DIV_N'({col_q, 17'b0});
        div_req_o.den   = DIV_D'(w_eff);
      end
      S_INVX_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = DIV_N'(1) << (2 * FRAC_BITS);
        div_req_o.den   = abs_x;
      end
      S_INVY_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = DIV_N'(1) << (2 * FRAC_BITS);
        div_req_o.den   = abs_y;
      end
      S_LINE_GO: begin
        div_req_o.start = (dist_q != '0);
        div_req_o.num   = DIV_N'({h_eff, 16'b0});
        div_req_o.den   = DIV_D'(dist_q);
      end
      default: ;
    endcase
  end

  // strip extent and face
  assign h2     = h_eff >> 1;
  assign l2     = line_q >> 1;
  assign top    = h2 - l2;
  assign bsum   = l2 + h2;
  assign bottom = (bsum >= h_eff) ? h_eff - 1'b1 : bsum;

  always_comb begin
    if (!side_q) begin
      face = ray_x_q[31] ? FACE_WEST : ((ray_x_q != '0) ? FACE_EAST : FACE_NORTH);
    end else begin
      face = (!ray_y_q[31] && (ray_y_q != '0)) ? FACE_SOUTH : FACE_NORTH;
    end
  end

  assign load_out = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (accept && (gdr_op_e'(s_axis_tuser) == OP_CAST)) state_d = S_CAM_GO;
      S_CAM_GO:    state_d = S_CAM_WAIT;
      S_CAM_WAIT:  if (div_rsp_i.done) state_d = S_MULX;
      S_MULX:      state_d = S_MULY;
      S_MULY:      state_d = S_RAYY;
      S_RAYY:      state_d = S_INVX_GO;
      S_INVX_GO:   state_d = S_INVX_WAIT;
      S_INVX_WAIT: if (div_rsp_i.done) state_d = S_INVY_GO;
      S_INVY_GO:   state_d = S_INVY_WAIT;
      S_INVY_WAIT: if (div_rsp_i.done) state_d = S_INITX;
      S_INITX:     state_d = S_INITY;
      S_INITY:     state_d = S_INITZ;
      S_INITZ:     state_d = S_STEP;
      S_STEP:      state_d = S_CHECK;
      S_CHECK:     state_d = (wall || (steps_q == STEP_W'(WALK_LIMIT))) ? S_DIST : S_STEP;
      S_DIST:      state_d = S_LINE_GO;
      S_LINE_GO:   state_d = (dist_q == '0) ? S_FIN : S_LINE_WAIT;
      S_LINE_WAIT: if (div_rsp_i.done) state_d = S_FIN;
      S_FIN:       if (load_out) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      steps_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (state_q == S_INITZ) begin
        steps_q <= '0;
      end else if (state_q == S_STEP) begin
        steps_q <= steps_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        col_q    <= s_axis_tdata[COL_W-1:0];
        cell_x_q <= {1'b0, cfg_i.player_x[POS_W-1:FRAC_BITS]};
        cell_y_q <= {1'b0, cfg_i.player_y[POS_W-1:FRAC_BITS]};
      end
      S_CAM_WAIT: cam_q <= signed'(29'(div_rsp_i.quo)) - 29'sd65536;
      S_MULX:     prod_q <= mul_a * mul_b;
      S_MULY: begin
        ray_x_q <= 32'(cfg_i.dir_x) + signed'(ray_trunc);
        prod_q  <= mul_a * mul_b;
      end
      S_RAYY:      ray_y_q <= 32'(cfg_i.dir_y) + signed'(ray_trunc);
      S_INVX_WAIT: step_x_q <= quo_sat;
      S_INVY_WAIT: step_y_q <= quo_sat;
      S_INITX:     prod_q <= mul_a * mul_b;
      S_INITY: begin
        cross_x_q <= prod_sat;
        prod_q    <= mul_a * mul_b;
      end
      S_INITZ:     cross_y_q <= prod_sat;
      S_STEP: begin
        if (take_x) begin
          cross_x_q <= nx_cross;
          cell_x_q  <= nx_cell;
          side_q    <= 1'b0;
        end else begin
          cross_y_q <= ny_cross;
          cell_y_q  <= ny_cell;
          side_q    <= 1'b1;
        end
      end
      S_DIST:    dist_q <= dist_diff[DIST_W] ? '0 : dist_diff[DIST_W-1:0];
      S_LINE_GO: line_q <= h_eff;
      S_LINE_WAIT: begin
        line_q <= (div_rsp_i.quo > DIV_N'(h_eff)) ? h_eff : div_rsp_i.quo[SCR_W-1:0];
      end
      default: ;
    endcase
    if (load_out) begin
      m_data_q <= {5'b0, cell_y_q[MAP_BITS-1:0], cell_x_q[MAP_BITS-1:0],
                   bottom[COL_W-1:0], top[COL_W-1:0], face, dist_q, col_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `GDR_ASSERT(a_no_take_in_clear, clear_busy_i |-> !s_axis_tready, "item taken during map clear")
  `GDR_ASSERT(a_div_start_idle, div_req_o.start |-> !div_rsp_i.busy, "divider restarted while busy")
  `GDR_ASSERT(a_walk_cap, steps_q <= STEP_W'(WALK_LIMIT), "walk ran past its cap")
  `GDR_ASSERT(a_map_write_idle, map_req_o.we |-> (state_q == S_IDLE), "map write during a cast")

endmodule

/* src/grid_dda_raycaster_top.sv */
// Cast: a cast walks N DDA steps (1 to 256), each a step state and a check state around
// the registered map read, and runs the bit-serial divider up to four times.
// A new item is taken while a result waits.
// Reset: asynchronous, active low; configuration and control registers return to
// defaults and the map is swept to open, during which no item is taken (config still is).
// ----------------------------------------------------------------------------
// Grid DDA raycaster top level
// Configuration registers, wall map, divider and cast sequencer.
// ----------------------------------------------------------------------------
module grid_dda_raycaster_top import gdr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [POS_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // column[9:0], cell_x[15:10], cell_y[21:16], cell_is_wall[22], zero[23]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_column[9:0], wall_distance[40:10], wall_face[42:41], strip_top[52:43],
  // strip_bottom[62:53], hit_x[68:63], hit_y[74:69], zero[79:75]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  gdr_cfg_t     cfg_q;
  gdr_map_req_t map_req;
  gdr_div_req_t div_req;
  gdr_div_rsp_t div_rsp;
  logic         map_rd, clear_busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.player_x <= 22'd131072;
      cfg_q.player_y <= 22'd131072;
      cfg_q.dir_x    <= 19'sd65536;
      cfg_q.dir_y    <= 19'sd0;
      cfg_q.plane_x  <= 19'sd0;
      cfg_q.plane_y  <= 19'sd43253;
      cfg_q.width    <= 11'd640;
      cfg_q.height   <= 11'd480;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gdr_cfg_idx_e'(cfg_index_i))
        CFG_PLAYER_X:      cfg_q.player_x <= cfg_data_i;
        CFG_PLAYER_Y:      cfg_q.player_y <= cfg_data_i;
        CFG_VIEW_DIR_X:    cfg_q.dir_x    <= signed'(cfg_data_i[VEC_W-1:0]);
        CFG_VIEW_DIR_Y:    cfg_q.dir_y    <= signed'(cfg_data_i[VEC_W-1:0]);
        CFG_CAM_PLANE_X:   cfg_q.plane_x  <= signed'(cfg_data_i[VEC_W-1:0]);
        CFG_CAM_PLANE_Y:   cfg_q.plane_y  <= signed'(cfg_data_i[VEC_W-1:0]);
        CFG_SCREEN_WIDTH:  cfg_q.width    <= cfg_data_i[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_q.height   <= cfg_data_i[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  gdr_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (map_req),
    .rd_data_o    (map_rd),
    .clear_busy_o (clear_busy)
  );

  gdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gdr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .clear_busy_i  (clear_busy),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .map_req_o     (map_req),
    .map_rd_data_i (map_rd),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp)
  );

endmodule

/* tb/sv/tb_grid_dda_raycaster_top.sv */
// ----------------------------------------------------------------------------
// Grid DDA raycaster testbench
// Drives map writes and column casts over the input stream, updates the view
// registers between phases while the block is idle, and checks each cast
// result against a fixed-point model of the DDA walk kept in this file.
// ----------------------------------------------------------------------------
module tb_grid_dda_raycaster_top import gdr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE       = 64'sd1 << FRAC_BITS;
  localparam longint SAT_LIMIT = 64'sh7FFFFFFF;

  typedef struct packed {
    logic [9:0]  column;
    logic [30:0] distance;
    logic [1:0]  face;
    logic [9:0]  top;
    logic [9:0]  bottom;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
  } strip_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i = '0;
  logic [POS_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  grid_dda_raycaster_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model state
  bit     wall_bits [MAP_CELLS];
  longint pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, scr_w, scr_h;
  strip_t pending_strips[$];
  int     errors = 0;
  int     burst_left = 0;

  function automatic longint step_length(input longint r);
    longint m, q;
    if (r == 0) return SAT_LIMIT;
    m = r < 0 ? -r : r;
    q = (64'sd1 << (2 * FRAC_BITS)) / m;
    return q > SAT_LIMIT ? SAT_LIMIT : q;
  endfunction

  function automatic longint scale_frac(input longint f, input longint len);
    longint p;
    p = (f * len) / ONE;
    return p > SAT_LIMIT ? SAT_LIMIT : p;
  endfunction

  function automatic strip_t cast_strip(input logic [9:0] col);
    longint w, h, cam, rx, ry, slx, sly, ncx, ncy, wall_dist, line, top, bot;
    int     cx, cy;
    bit     y_side;
    strip_t r;
    w = scr_w == 0 ? 1 : scr_w;
    h = scr_h == 0 ? 1 : scr_h;
    if (h > MAX_SCREEN) h = MAX_SCREEN;
    cam = (2 * longint'(col) * ONE) / w - ONE;
    rx = dir_x + (plane_x * cam) / ONE;
    ry = dir_y + (plane_y * cam) / ONE;
    slx = step_length(rx);
    sly = step_length(ry);
    cx = int'(pos_x / ONE);
    cy = int'(pos_y / ONE);
    ncx = rx < 0 ? scale_frac(pos_x - cx * ONE, slx) : scale_frac((cx + 1) * ONE - pos_x, slx);
    ncy = ry < 0 ? scale_frac(pos_y - cy * ONE, sly) : scale_frac((cy + 1) * ONE - pos_y, sly);
    y_side = 1'b0;
    for (int n = 0; n < WALK_LIMIT; n++) begin
      if (ncx < ncy) begin
        ncx = ncx + slx > SAT_LIMIT ? SAT_LIMIT : ncx + slx;
        cx += rx < 0 ? -1 : 1;
        y_side = 1'b0;
      end else begin
        ncy = ncy + sly > SAT_LIMIT ? SAT_LIMIT : ncy + sly;
        cy += ry < 0 ? -1 : 1;
        y_side = 1'b1;
      end
      if (cx < 0) cx = 0;
      if (cy < 0) cy = 0;
      if (cx >= MAP_SIDE || cy >= MAP_SIDE || wall_bits[cy * MAP_SIDE + cx]) break;
    end
    wall_dist = y_side ? ncy - sly : ncx - slx;
    if (wall_dist < 0) wall_dist = 0;
    if (wall_dist == 0) line = h;
    else begin
      line = (h * ONE) / wall_dist;
      if (line > h) line = h;
    end
    top = h / 2 - line / 2;
    if (top < 0) top = 0;
    bot = line / 2 + h / 2;
    if (bot >= h) bot = h - 1;
    if (!y_side && rx > 0) r.face = FACE_EAST;
    else if (!y_side && rx < 0) r.face = FACE_WEST;
    else if (y_side && ry > 0) r.face = FACE_SOUTH;
    else r.face = FACE_NORTH;
    r.column   = col;
    r.distance = wall_dist[30:0];
    r.top      = top[9:0];
    r.bottom   = bot[9:0];
    r.hit_x    = cx[5:0];
    r.hit_y    = cy[5:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    strip_t exp_s, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.column   = m_axis_tdata[9:0];
      got.distance = m_axis_tdata[40:10];
      got.face     = m_axis_tdata[42:41];
      got.top      = m_axis_tdata[52:43];
      got.bottom   = m_axis_tdata[62:53];
      got.hit_x    = m_axis_tdata[68:63];
      got.hit_y    = m_axis_tdata[74:69];
      if (pending_strips.size() == 0) begin
        errors++;
        $display("%0t unexpected result %p", $realtime, got);
      end else begin
        exp_s = pending_strips.pop_front();
        if (got.column !== exp_s.column) begin
          errors++;
          $display("%0t column exp %0d got %0d", $realtime, exp_s.column, got.column);
        end
        if (got.distance !== exp_s.distance) begin
          errors++;
          $display("%0t distance exp %0d got %0d", $realtime, exp_s.distance, got.distance);
        end
        if (got.face !== exp_s.face) begin
          errors++;
          $display("%0t face exp %0d got %0d", $realtime, exp_s.face, got.face);
        end
        if (got.top !== exp_s.top) begin
          errors++;
          $display("%0t top exp %0d got %0d", $realtime, exp_s.top, got.top);
        end
        if (got.bottom !== exp_s.bottom) begin
          errors++;
          $display("%0t bottom exp %0d got %0d", $realtime, exp_s.bottom, got.bottom);
        end
        if (got.hit_x !== exp_s.hit_x) begin
          errors++;
          $display("%0t hit_x exp %0d got %0d", $realtime, exp_s.hit_x, got.hit_x);
        end
        if (got.hit_y !== exp_s.hit_y) begin
          errors++;
          $display("%0t hit_y exp %0d got %0d", $realtime, exp_s.hit_y, got.hit_y);
        end
      end
    end
  end

  // receiver stall pattern
  int rx_cnt = 0;
  int rx_mode = 0;
  always @(negedge clk_i) begin
    rx_cnt++;
    if (rx_cnt % 50 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = 1'($urandom_range(0, 1));
      default: m_axis_tready = ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_item(input gdr_op_e op, input logic [9:0] col, input logic [5:0] x,
                           input logic [5:0] y, input logic wall);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {1'b0, wall, y, x, col};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_WRITE) wall_bits[y * MAP_SIDE + x] = wall;
    else pending_strips.push_back(cast_strip(col));
    @(negedge clk_i);
  endtask

  task automatic cast(input logic [9:0] col);
    send_item(OP_CAST, col, 6'($urandom()), 6'($urandom()), 1'($urandom()));
  endtask

  task automatic put_cell(input int x, input int y, input bit wall);
    send_item(OP_WRITE, 10'($urandom()), 6'(x), 6'(y), wall);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_strips.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(input gdr_cfg_idx_e idx, input longint v);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v[POS_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PLAYER_X:      pos_x   = v[21:0];
      CFG_PLAYER_Y:      pos_y   = v[21:0];
      CFG_VIEW_DIR_X:    dir_x   = longint'($signed(v[18:0]));
      CFG_VIEW_DIR_Y:    dir_y   = longint'($signed(v[18:0]));
      CFG_CAM_PLANE_X:   plane_x = longint'($signed(v[18:0]));
      CFG_CAM_PLANE_Y:   plane_y = longint'($signed(v[18:0]));
      CFG_SCREEN_WIDTH:  scr_w   = v[10:0];
      default:           scr_h   = v[10:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_view(input longint px, input longint py, input longint dx,
                          input longint dy, input longint qx, input longint qy,
                          input longint w, input longint h);
    wait_idle();
    write_reg(CFG_PLAYER_X, px);
    write_reg(CFG_PLAYER_Y, py);
    write_reg(CFG_VIEW_DIR_X, dx);
    write_reg(CFG_VIEW_DIR_Y, dy);
    write_reg(CFG_CAM_PLANE_X, qx);
    write_reg(CFG_CAM_PLANE_Y, qy);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
  endtask

  task automatic test_defaults();
    cast(0);
    cast(319);
    cast(639);
    cast(1023);
  endtask

  task automatic test_faces();
    put_cell(5, 2, 1);
    put_cell(0, 2, 1);
    put_cell(2, 5, 1);
    put_cell(2, 0, 1);
    set_view(2 * ONE + 30000, 2 * ONE + 20000, 0, 0, 0, 0, 1, 1);
    write_reg(CFG_VIEW_DIR_X, 131072);
    cast(0);
    wait_idle();
    write_reg(CFG_VIEW_DIR_X, -131072);
    cast(0);
    set_view(2 * ONE + 30000, 2 * ONE + 20000, 0, 131072, 0, 0, 1, 1);
    cast(0);
    wait_idle();
    write_reg(CFG_VIEW_DIR_Y, -131072);
    cast(0);
    put_cell(5, 2, 0);
  endtask

  task automatic test_corner_cases();
    // both ray components zero; walk capped while x keeps clamping at zero
    set_view(ONE / 2, 3 * ONE, 0, 0, 0, 0, 640, 480);
    cast(100);
    set_view(ONE / 2, 10 * ONE, -65536, 1, 0, 0, 640, 480);
    cast(7);
    // extreme positions and screen sizes
    set_view(4194303, 0, 65536, 65536, 131072, -131072, 0, 0);
    cast(1023);
    set_view(0, 4194303, -65536, -65536, -131072, 131072, 2047, 2047);
    cast(0);
    cast(1023);
    set_view(33 * ONE, 33 * ONE, 65536, 4000, 0, 43253, 1024, 1);
    cast(512);
    cast(1023);
  endtask

  task automatic test_random();
    int items;
    items = 0;
    while (items < 1250) begin
      if (items % 125 == 0) begin
        if ($urandom_range(0, 3) == 0)
          set_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom_range(0, 2047), $urandom_range(0, 2047));
        else
          set_view($urandom_range(ONE, 63 * ONE - 1), $urandom_range(ONE, 63 * ONE - 1),
                   longint'($urandom_range(0, 262144)) - 131072,
                   longint'($urandom_range(0, 262144)) - 131072,
                   longint'($urandom_range(0, 131072)) - 65536,
                   longint'($urandom_range(0, 131072)) - 65536,
                   $urandom_range(1, 1024), $urandom_range(1, 1024));
      end
      if ($urandom_range(0, 9) < 3)
        put_cell($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      else
        cast(10'($urandom_range(0, scr_w > 1024 || scr_w == 0 ? 1023 : scr_w + 2)));
      items++;
    end
  endtask

  initial begin
    pos_x = 131072; pos_y = 131072; dir_x = 65536; dir_y = 0;
    plane_x = 0; plane_y = 43253; scr_w = 640; scr_h = 480;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_defaults();
    test_faces();
    test_corner_cases();
    test_random();
    wait_idle();
    repeat (700) @(negedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
